FILE: src/stoa_pkg.sv
package stoa_pkg;

  localparam int unsigned SLOTS      = 64;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [VALUE_BITS-1:0] entry_value;
    logic [IDX_W-1:0]      ordinal;
  } stoa_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IDX_W-1:0]      slot_index;
    logic [VALUE_BITS-1:0] found_value;
    logic [CNT_W-1:0]      occupied_count;
  } stoa_out_t;

  typedef struct packed {
    logic             start;
    logic             find_free;
    logic [IDX_W-1:0] ordinal;
  } stoa_scan_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic [IDX_W-1:0] idx;
  } stoa_scan_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_RESP
  } stoa_state_e;

endpackage

FILE: src/slot_table_ordinal_access_core.sv
// Slot table of 64 data words with an occupied mark each. An append stores its
// value in the lowest free slot; remove and find select the n-th occupied slot in
// slot order. One beat is handled at a time: a scanner walks the occupied marks one
// slot per cycle, up to the target slot or, on a miss (full table or ordinal beyond
// occupancy), to the last slot; an unused action code skips the scan. The value
// memory is accessed at most once per operation, with a registered read on find
// and remove. A finished result waits in an output register, so the next beat is
// taken while it is still unread.
module slot_table_ordinal_access_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stoa_pkg::stoa_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stoa_pkg::stoa_out_t  out_data_o
);
  import stoa_pkg::*;

  stoa_state_e      state_q, state_d;
  logic [SLOTS-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  stoa_in_t         req_q, req_d;
  stoa_out_t        res_q, res_d;
  stoa_out_t        out_data_q, out_data_d;

  stoa_scan_ctrl_t       scan_ctrl;
  stoa_scan_stat_t       scan_stat;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_addr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic                  in_fire;

  assign in_fire = in_valid_i && (state_q == S_IDLE);

  stoa_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .occ_i  (occ_q),
    .stat_o (scan_stat)
  );

  stoa_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (req_q.entry_value),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = scan_stat.idx;

    scan_ctrl.start     = 1'b0;
    scan_ctrl.find_free = (req_q.action == ACT_APPEND);
    scan_ctrl.ordinal   = req_q.ordinal;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d        = in_data_i;
          res_d        = '0;
          res_d.status = ST_OK;
          case (in_data_i.action)
            ACT_APPEND, ACT_REMOVE, ACT_FIND: begin
              scan_ctrl.start = 1'b1;
              state_d         = S_SCAN;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_stat.miss) begin
          res_d.status = (req_q.action == ACT_APPEND) ? ST_FULL : ST_NOT_FOUND;
          state_d      = S_RESP;
        end else if (scan_stat.hit) begin
          res_d.slot_index = scan_stat.idx;
          if (req_q.action == ACT_APPEND) begin
            mem_we                = 1'b1;
            occ_d[scan_stat.idx]  = 1'b1;
            count_d               = count_q + CNT_W'(1);
            state_d               = S_RESP;
          end else begin
            mem_re  = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        res_d.found_value = mem_rdata;
        if (req_q.action == ACT_REMOVE) begin
          occ_d[res_q.slot_index] = 1'b0;
          count_d                 = count_q - CNT_W'(1);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        // The count has already settled, so it is taken here.
        if (!out_valid_q || out_ready_i) begin
          out_data_d                = res_q;
          out_data_d.occupied_count = count_q;
          out_valid_d               = 1'b1;
          state_d                   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == 32'($countones(occ_q)))
    else $error("occupied count differs from the number of occupied marks");

  a_scan_result_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_stat.hit || scan_stat.miss) |-> (state_q == S_SCAN))
    else $error("scanner reported outside the scan state");

  a_scan_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(scan_stat.hit && scan_stat.miss))
    else $error("scanner reported hit and miss together");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_valid_q && !out_ready_i) |=> (state_q == S_RESP))
    else $error("result left the response state while the output register was full");

endmodule

FILE: src/stoa_scan.sv
module stoa_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stoa_pkg::stoa_scan_ctrl_t     ctrl_i,
  input  logic [stoa_pkg::SLOTS-1:0]    occ_i,
  output stoa_pkg::stoa_scan_stat_t     stat_o
);
  import stoa_pkg::*;

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic             hit_q, hit_d;
  logic             miss_q, miss_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             mark;
  logic             match;
  logic             last;

  // One slot mark is examined per cycle; seen_q counts the occupied slots
  // passed so far, so the n-th occupied slot, counting from zero, is the one met with seen_q == n.
  always_comb begin
    mark      = occ_i[idx_q];
    last      = (idx_q == IDX_W'(SLOTS - 1));
    match     = busy_q && (ctrl_i.find_free ? !mark
                                            : (mark && (seen_q == CNT_W'(ctrl_i.ordinal))));
    busy_d    = busy_q;
    idx_d     = idx_q;
    seen_d    = seen_q;
    hit_d     = 1'b0;
    miss_d    = 1'b0;
    hit_idx_d = hit_idx_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      seen_d = '0;
    end else if (busy_q) begin
      if (match) begin
        busy_d    = 1'b0;
        hit_d     = 1'b1;
        hit_idx_d = idx_q;
      end else if (last) begin
        busy_d = 1'b0;
        miss_d = 1'b1;
      end else begin
        idx_d  = idx_q + IDX_W'(1);
        seen_d = seen_q + CNT_W'(mark);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      seen_q <= '0;
      hit_q  <= 1'b0;
      miss_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      seen_q <= seen_d;
      hit_q  <= hit_d;
      miss_q <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
  end

  assign stat_o.hit  = hit_q;
  assign stat_o.miss = miss_q;
  assign stat_o.idx  = hit_idx_q;

endmodule

FILE: src/stoa_mem.sv
module stoa_mem (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic                               re_i,
  input  logic [stoa_pkg::IDX_W-1:0]         addr_i,
  input  logic [stoa_pkg::VALUE_BITS-1:0]    wdata_i,
  output logic [stoa_pkg::VALUE_BITS-1:0]    rdata_o
);
  import stoa_pkg::*;

  logic [VALUE_BITS-1:0] mem_q [SLOTS];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
